/* sv/bcd_pkg.sv */
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants of the binary to BCD converter
// Holds the digit register geometry, the default byte limit and the control
// bundle that drives the digit shift register.
// ----------------------------------------------------------------------------
package bcd_pkg;

  // Geometry of the decimal digit register.
  localparam int unsigned NumDigits  = 20;
  localparam int unsigned NumPairs   = NumDigits / 2;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned PairW      = 2 * DigitW;
  localparam int unsigned PairIdxW   = $clog2(NumPairs);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitCntW    = $clog2(ByteW);

  // Default limit on bytes per number.
  localparam int unsigned MaxBytesDef = 8;

  // A digit of this value or more gets the correction added before a shift.
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  // Control bundle from the sequencer to the digit shift register.
  typedef struct packed {
    logic load;   // Capture a new input byte.
    logic shift;  // Take one bit of the byte into the digits.
    logic clear;  // Return the digits to zero.
  } dabble_ctrl_t;

  typedef logic [NumPairs-1:0][PairW-1:0] pair_vec_t;

endpackage

/* sv/bcd_dabble.sv */
// ----------------------------------------------------------------------------
// bcd_dabble: bit-serial double dabble digit register
// Holds the current byte in a shift register and, while shift is set, moves
// one bit per cycle, MSB first, into twenty BCD digits with the add-three rule.
// ----------------------------------------------------------------------------
module bcd_dabble (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bcd_pkg::dabble_ctrl_t      ctrl_i,
  input  logic [bcd_pkg::ByteW-1:0]  byte_i,
  output bcd_pkg::pair_vec_t         pairs_o
);
  import bcd_pkg::*;

  logic [ByteW-1:0]                   byte_d, byte_q;
  logic [NumDigits-1:0][DigitW-1:0]   dig_d, dig_q;
  logic [NumDigits-1:0][DigitW-1:0]   adj;
  logic [NumDigits-1:0][DigitW-1:0]   shifted;

  // Byte shift register; a new byte may load on the last shift of the previous one.
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = {byte_q[ByteW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // Correct every digit of five or more, then shift the whole register by one bit.
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      adj[d] = (dig_q[d] >= DabbleLimit) ? dig_q[d] + DabbleAdd : dig_q[d];
    end
    shifted[0] = {adj[0][DigitW-2:0], byte_q[ByteW-1]};
    for (int d = 1; d < NumDigits; d++) begin
      shifted[d] = {adj[d][DigitW-2:0], adj[d-1][DigitW-1]};
    end
  end

  always_comb begin
    dig_d = dig_q;
    if (ctrl_i.clear) begin
      dig_d = '0;
    end else if (ctrl_i.shift) begin
      dig_d = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q <= '0;
    end else begin
      dig_q <= dig_d;
    end
  end

  // Present the digits as packed pairs, low digit in the low nibble.
  always_comb begin
    for (int p = 0; p < NumPairs; p++) begin
      pairs_o[p] = {dig_q[2*p+1], dig_q[2*p]};
    end
  end

endmodule

/* sv/binary_to_bcd_converter.sv */
// ----------------------------------------------------------------------------
// binary_to_bcd_converter: streaming binary to packed BCD converter
// Sequencer, significance scan and output register around the digit register.
// ----------------------------------------------------------------------------
// A number arrives as a run of bytes, most significant first, ending with
// tlast. Each byte is shifted one bit per cycle into the double dabble digit
// register, and the next byte is taken on the last of those shifts. After the
// last byte a scan walks the ten digit pairs from the top, one per cycle, to
// find the significant ones; then the pairs leave least significant first,
// one beat per cycle while the sink is ready. Bytes beyond MAX_BYTES are
// dropped and raise the overflow flag in tuser on every pair of that number.
// No input is taken while a result is scanned or sent.
module binary_to_bcd_converter #(
  parameter int unsigned MAX_BYTES = bcd_pkg::MaxBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beat: tdata = data_byte[7:0]; tlast = last_byte.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  // Output beat: tdata = bcd_pair[7:0], pair_index[11:8], pair_count[15:12];
  // tlast = last_pair; tuser = overflow.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o
);
  import bcd_pkg::*;

  localparam int unsigned BytesW = $clog2(MAX_BYTES + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StShift = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]          state_d, state_q;
  logic [BitCntW-1:0]  bit_d, bit_q;
  logic [BytesW-1:0]   bytes_d, bytes_q;
  logic                last_d, last_q;
  logic                ovf_d, ovf_q;
  logic [PairIdxW-1:0] scan_d, scan_q;
  logic [PairIdxW-1:0] idx_d, idx_q;
  logic [PairIdxW-1:0] cnt_d, cnt_q;
  logic [PairW-1:0]    pair_d, pair_q;
  logic                vld_d, vld_q;

  logic                in_fire, out_fire, take, hit, done, out_last;
  logic                shift_end;
  logic [PairIdxW-1:0] idx_nxt;
  dabble_ctrl_t        ctrl;
  pair_vec_t           pairs;

  assign shift_end = (state_q == StShift) && (bit_q == BitCntW'(ByteW - 1));
  assign s_axis_tready_o = (state_q == StIdle) || (shift_end && !last_q);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign take     = in_fire && (bytes_q < BytesW'(MAX_BYTES));
  assign out_fire = vld_q && m_axis_tready_i;
  assign idx_nxt  = idx_q + 1'b1;
  assign out_last = (idx_nxt == cnt_q);
  assign done     = out_fire && out_last;
  assign hit      = (pairs[scan_q] != '0) || (scan_q == '0);

  assign ctrl.load  = take;
  assign ctrl.shift = (state_q == StShift);
  assign ctrl.clear = done;

  bcd_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .byte_i  (s_axis_tdata_i),
    .pairs_o (pairs)
  );

  // Sequencer: byte intake, bit shifting, significance scan and pair output.
  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    bytes_d = bytes_q;
    last_d  = last_q;
    ovf_d   = ovf_q;
    scan_d  = PairIdxW'(NumPairs - 1);
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    pair_d  = pair_q;
    vld_d   = vld_q;

    if (state_q == StShift) begin
      bit_d = bit_q + 1'b1;
    end

    // A byte beat taken in idle or on the last shift cycle of a byte.
    if (in_fire) begin
      last_d = s_axis_tlast_i;
      if (take) begin
        bytes_d = bytes_q + 1'b1;
        bit_d   = '0;
        state_d = StShift;
      end else begin
        ovf_d   = 1'b1;
        state_d = s_axis_tlast_i ? StScan : StIdle;
      end
    end else if (shift_end) begin
      state_d = last_q ? StScan : StIdle;
    end

    case (state_q)
      StScan: begin
        if (hit) begin
          cnt_d   = scan_q + 1'b1;
          idx_d   = '0;
          pair_d  = pairs[0];
          vld_d   = 1'b1;
          state_d = StEmit;
        end else begin
          scan_d = scan_q - 1'b1;
        end
      end
      StEmit: begin
        if (done) begin
          vld_d   = 1'b0;
          bytes_d = '0;
          ovf_d   = 1'b0;
          last_d  = 1'b0;
          state_d = StIdle;
        end else if (out_fire) begin
          idx_d  = idx_nxt;
          pair_d = pairs[idx_nxt];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bit_q   <= '0;
      bytes_q <= '0;
      last_q  <= 1'b0;
      ovf_q   <= 1'b0;
      scan_q  <= PairIdxW'(NumPairs - 1);
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      bytes_q <= bytes_d;
      last_q  <= last_d;
      ovf_q   <= ovf_d;
      scan_q  <= scan_d;
      vld_q   <= vld_d;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    pair_q <= pair_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {cnt_q, idx_q, pair_q};
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tuser_o  = ovf_q;

endmodule

/* sv/bcd_checker.sv */
// ----------------------------------------------------------------------------
// bcd_checker: port-level checks of the binary to BCD converter
// Watches the stream ports for output ordering and handshake consistency.
// ----------------------------------------------------------------------------
module bcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  // No byte is taken while pairs are being sent.
  a_no_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while result pending");

  // The pair index stays below the pair count, which is one to ten.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[11:8] < m_axis_tdata_o[15:12]) &&
      (m_axis_tdata_o[15:12] <= 4'd10))
    else $error("pair index or count out of range");

  // After a non-final pair is taken, the next beat carries the following index.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o &&
      (m_axis_tdata_o[11:8] == $past(m_axis_tdata_o[11:8]) + 4'd1))
    else $error("pair index did not advance by one");

endmodule

bind binary_to_bcd_converter bcd_checker u_bcd_checker (.*);

/* bench/binary_to_bcd_converter_tb.sv */
// ----------------------------------------------------------------------------
// binary_to_bcd_converter_tb: self-checking bench for the BCD converter
// Streams multi-byte binary numbers into the converter. A double dabble
// predictor keeps its own digit register and expects the emitted digit pairs.
// Each output beat is checked against the oldest expected pair. Both stream
// sides idle at random. One long sink stall backs up the input, and two
// source pauses wait for the pairs to drain.
// ----------------------------------------------------------------------------
module binary_to_bcd_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxBytes   = bcd_pkg::MaxBytesDef;
  localparam int unsigned NumDigits  = bcd_pkg::NumDigits;
  localparam int unsigned NumPairs   = bcd_pkg::NumPairs;
  localparam int unsigned RandItems  = 446;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned LongHold   = 400;

  // One input byte of a number, or a marker that makes the source wait.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } num_byte_t;

  // One output digit pair, laid out like the output beat.
  typedef struct packed {
    logic       ovf;
    logic       last;
    logic [3:0] count;
    logic [3:0] index;
    logic [7:0] pair;
  } bcd_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_last;
  logic        m_user;

  num_byte_t   byte_q[$];
  bcd_beat_t   pair_q[$];
  int unsigned errors = 0;
  int unsigned items_taken = 0;
  int unsigned cycles = 0;

  // Predictor state: decimal digits, bytes taken and the overflow flag.
  logic [3:0]  dig[NumDigits];
  int unsigned bytes_seen = 0;
  logic        ovf_seen = 1'b0;

  binary_to_bcd_converter #(
    .MAX_BYTES(MaxBytes)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .m_axis_tuser_o (m_user)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int d = 0; d < NumDigits; d++) dig[d] = '0;
  end

  // Double dabble on one accepted byte; on the last byte, queue the pairs.
  task automatic convert_byte(input logic [7:0] data, input logic last);
    logic [4:0]  nd;
    logic        carry;
    int          top;
    int unsigned cnt;
    bcd_beat_t   bt;
    if (bytes_seen < MaxBytes) begin
      for (int b = 7; b >= 0; b--) begin
        carry = data[b];
        for (int d = 0; d < NumDigits; d++) begin
          if (dig[d] >= bcd_pkg::DabbleLimit) dig[d] = dig[d] + bcd_pkg::DabbleAdd;
        end
        // The carry out of the top digit is dropped.
        for (int d = 0; d < NumDigits; d++) begin
          nd     = {dig[d], carry};
          carry  = nd[4];
          dig[d] = nd[3:0];
        end
      end
      bytes_seen++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) begin
      top = -1;
      for (int d = NumDigits - 1; d >= 0; d--) begin
        if (top < 0 && dig[d] != '0) top = d;
      end
      cnt = (top >= 0) ? top / 2 + 1 : 1;
      for (int k = 0; k < cnt && k < NumPairs; k++) begin
        bt.pair  = {dig[2*k+1], dig[2*k]};
        bt.index = 4'(k);
        bt.count = 4'(cnt);
        bt.last  = (k + 1 == cnt);
        bt.ovf   = ovf_seen;
        pair_q.push_back(bt);
      end
      for (int d = 0; d < NumDigits; d++) dig[d] = '0;
      bytes_seen = 0;
      ovf_seen   = 1'b0;
    end
  endtask

  function automatic void add_byte(input logic [7:0] data, input logic last);
    byte_q.push_back('{data: data, last: last, drain: 1'b0});
  endfunction

  function automatic void add_drain();
    byte_q.push_back('{data: 8'h00, last: 1'b0, drain: 1'b1});
  endfunction

  // Source: bursts of random length with random gaps; a marker pauses it
  // until every expected pair has come back.
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  logic        draining = 1'b0;
  num_byte_t   next_byte;

  always @(posedge clk) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        convert_byte(s_data, s_last);
        items_taken <= items_taken + 1;
      end
      if (!s_valid || s_ready) begin
        if (draining && pair_q.size() == 0) draining = 1'b0;
        while (!draining && byte_q.size() > 0 && byte_q[0].drain) begin
          void'(byte_q.pop_front());
          draining = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (draining || byte_q.size() == 0) begin
          s_valid <= 1'b0;
        end else begin
          next_byte = byte_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= next_byte.data;
          s_last  <= next_byte.last;
          burst_left--;
          if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // Sink: stall pattern chosen per segment, plus one long hold-off once the
  // input has been running for a while.
  int unsigned rx_mode = 0;
  int unsigned rx_seg_left = 0;
  int unsigned rx_phase = 0;
  int unsigned hold_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk) begin
    rx_phase++;
    if (rx_seg_left == 0) begin
      rx_mode     = $urandom_range(0, 3);
      rx_seg_left = $urandom_range(20, 200);
    end else begin
      rx_seg_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (!long_hold_done && items_taken >= 150) begin
      long_hold_done = 1'b1;
      hold_left      = LongHold;
      m_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          m_ready <= 1'b1;
        end
        1: begin
          m_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          m_ready <= (rx_phase % 4 == 0);
        end
        default: begin
          m_ready <= rx_phase[0];
        end
      endcase
    end
  end

  // Output check against the oldest expected pair.
  bcd_beat_t got_beat;
  bcd_beat_t want_beat;

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      got_beat = {m_user, m_last, m_data[15:12], m_data[11:8], m_data[7:0]};
      if (pair_q.size() == 0) begin
        errors++;
        $display("%0t: extra beat: expected none, actual pair=%h idx=%0d cnt=%0d last=%b ovf=%b",
                 $time, got_beat.pair, got_beat.index, got_beat.count, got_beat.last,
                 got_beat.ovf);
      end else begin
        want_beat = pair_q.pop_front();
        if (got_beat !== want_beat) begin
          errors++;
          $display("%0t: pair mismatch: expected pair=%h idx=%0d cnt=%0d last=%b ovf=%b",
                   $time, want_beat.pair, want_beat.index, want_beat.count,
                   want_beat.last, want_beat.ovf);
          $display("%0t:                actual   pair=%h idx=%0d cnt=%0d last=%b ovf=%b",
                   $time, got_beat.pair, got_beat.index, got_beat.count, got_beat.last,
                   got_beat.ovf);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("binary_to_bcd_converter verification failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  int unsigned n_items;
  int unsigned n_numbers;
  int unsigned len;
  int unsigned style;
  int unsigned pick;
  logic [7:0]  b;

  initial begin
    // Directed numbers: zero, single bytes, the largest value, 256 and
    // an overflowing run whose ignored byte carries the last flag.
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h80, 1'b1);
    add_byte(8'd99, 1'b1);
    add_byte(8'd100, 1'b1);
    for (int i = 0; i < MaxBytes; i++) add_byte(8'hFF, i == MaxBytes - 1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b1);
    for (int i = 0; i < MaxBytes; i++) add_byte(8'(8'h12 + 8'h22 * i), 1'b0);
    add_byte(8'hAB, 1'b1);
    add_drain();

    // Random numbers, mostly short, some overflowing.
    n_items   = 0;
    n_numbers = 0;
    while (n_items < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) len = $urandom_range(1, 3);
      else if (pick < 88) len = $urandom_range(4, MaxBytes);
      else len = $urandom_range(MaxBytes + 1, MaxBytes + 4);
      style = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: b = 8'hFF;
          1: b = 8'h00;
          2: b = (i < len / 2) ? 8'h00 : 8'($urandom_range(0, 255));
          3: b = 8'($urandom_range(0, 9));
          default: b = 8'($urandom_range(0, 255));
        endcase
        add_byte(b, i == len - 1);
      end
      n_items += len;
      n_numbers++;
      if (n_numbers == 40) add_drain();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || s_valid || draining) @(posedge clk);
    while (pair_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("binary_to_bcd_converter verification clean");
    end else begin
      $display("binary_to_bcd_converter verification failed");
    end
    $finish;
  end

endmodule
